// ===== hw/rtl/sspst_pkg.sv =====
// Shared types and constants for the SYN scan port state table.
package sspst_pkg;

    localparam int PORT_BITS_DEF = 16;

    localparam logic [1:0] ST_UNKNOWN = 2'd0;
    localparam logic [1:0] ST_SENT    = 2'd1;
    localparam logic [1:0] ST_OPEN    = 2'd2;
    localparam logic [1:0] ST_CLOSED  = 2'd3;

    localparam logic [1:0] ACT_MARK  = 2'd0;
    localparam logic [1:0] ACT_REPLY = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    localparam logic [1:0] REG_TARGET_ADDR = 2'd0;
    localparam logic [1:0] REG_FIRST_PORT  = 2'd1;
    localparam logic [1:0] REG_LAST_PORT   = 2'd2;

    localparam logic [7:0]  FLAG_SYN     = 8'h02;
    localparam logic [7:0]  FLAG_RST     = 8'h04;
    localparam logic [7:0]  FLAG_ACK     = 8'h10;
    localparam logic [7:0]  PROTO_TCP    = 8'd6;
    localparam logic [16:0] IP_TCP_BASE  = 17'd20;

    localparam logic [31:0] TARGET_ADDR_RST = 32'd0;
    localparam logic [15:0] FIRST_PORT_RST  = 16'd1;
    localparam logic [15:0] LAST_PORT_RST   = 16'd65535;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] port;
        logic [31:0] source_addr;
        logic [7:0]  protocol;
        logic [3:0]  header_words;
        logic [15:0] packet_length;
        logic [7:0]  tcp_flags;
    } in_t;

    typedef struct packed {
        logic [1:0] port_status;
        logic       grab_banner;
        logic       ignored;
    } out_t;

    typedef struct packed {
        logic [31:0] target_addr;
        logic [15:0] first_port;
        logic [15:0] last_port;
    } cfg_t;

endpackage

// ===== hw/rtl/sspst_ram.sv =====
// Generic simple dual-port RAM, registered read-first output.
module sspst_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/sspst_update.sv =====
// Reply checks and port state transition for one transaction.
module sspst_update (
    input  sspst_pkg::in_t     item,
    input  logic [1:0]         cur_state,
    input  sspst_pkg::cfg_t    cfg,
    output sspst_pkg::out_t    result
);

    logic        addr_ok;
    logic        proto_ok;
    logic        len_ok;
    logic        range_ok;
    logic [16:0] min_len;
    logic        syn_ack;
    logic        rst;

    assign min_len  = {11'd0, item.header_words, 2'b00} + sspst_pkg::IP_TCP_BASE;
    assign addr_ok  = (item.source_addr == cfg.target_addr);
    assign proto_ok = (item.protocol == sspst_pkg::PROTO_TCP);
    assign len_ok   = ({1'b0, item.packet_length} >= min_len);
    assign range_ok = (item.port >= cfg.first_port) && (item.port <= cfg.last_port);
    assign syn_ack  = ((item.tcp_flags & (sspst_pkg::FLAG_SYN | sspst_pkg::FLAG_ACK))
                      == (sspst_pkg::FLAG_SYN | sspst_pkg::FLAG_ACK));
    assign rst      = ((item.tcp_flags & sspst_pkg::FLAG_RST) != 8'd0);

    always_comb begin
        result.port_status = cur_state;
        result.grab_banner = 1'b0;
        result.ignored     = 1'b0;
        case (item.action)
            sspst_pkg::ACT_MARK: begin
                if (cur_state == sspst_pkg::ST_UNKNOWN) begin
                    result.port_status = sspst_pkg::ST_SENT;
                end
            end
            sspst_pkg::ACT_REPLY: begin
                if (!(addr_ok && proto_ok && len_ok && range_ok)) begin
                    result.ignored = 1'b1;
                end else if (cur_state == sspst_pkg::ST_SENT) begin
                    if (syn_ack) begin
                        result.port_status = sspst_pkg::ST_OPEN;
                        result.grab_banner = 1'b1;
                    end else if (rst) begin
                        result.port_status = sspst_pkg::ST_CLOSED;
                    end
                end
            end
            default: begin
                result.port_status = cur_state;
            end
        endcase
    end

endmodule

// ===== hw/rtl/syn_scan_port_state_table_top.sv =====
// Top level of the SYN scan port state table.
//
//  channel | handshake                   | payload
//  --------+-----------------------------+------------------------------
//  s_      | s_valid / s_ready           | s_data (sspst_pkg::in_t)
//  m_      | m_valid / m_ready           | m_data (sspst_pkg::out_t)
//  cfg_    | cfg_we (no back-pressure)   | cfg_addr, cfg_wdata
//
// One transaction per cycle while s_ready is high; each result passes the table read
// and update stage, then the output register. Same-port back-to-back
// transactions use a forwarded state.
// After reset the table is swept to unknown, one entry per cycle, over all
// 2**PORT_BITS entries with s_ready low; cfg writes are taken throughout.
// A stalled result holds the update stage; s_ready drops only then and during the sweep.
module syn_scan_port_state_table_top #(
    parameter int PORT_BITS = sspst_pkg::PORT_BITS_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  sspst_pkg::in_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output sspst_pkg::out_t m_data,
    input  logic            cfg_we,
    input  logic [1:0]      cfg_addr,
    input  logic [31:0]     cfg_wdata
);

    localparam int DEPTH = 2 ** PORT_BITS;

    sspst_pkg::cfg_t cfg_reg;

    logic                 clr_active_reg;
    logic [PORT_BITS-1:0] clr_addr_reg;

    logic            p1_valid_reg;
    sspst_pkg::in_t  p1_item_reg;
    logic            fwd_hit_reg;
    logic [1:0]      fwd_data_reg;

    logic            m_valid_reg;
    sspst_pkg::out_t m_data_reg;

    logic                 accept;
    logic                 p1_adv;
    logic [1:0]           rd_state;
    logic [1:0]           cur_state;
    sspst_pkg::out_t      upd;
    logic                 ram_we;
    logic [PORT_BITS-1:0] ram_waddr;
    logic [1:0]           ram_wdata;
    logic                 fwd_hit_next;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_addr <= sspst_pkg::TARGET_ADDR_RST;
            cfg_reg.first_port  <= sspst_pkg::FIRST_PORT_RST;
            cfg_reg.last_port   <= sspst_pkg::LAST_PORT_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                sspst_pkg::REG_TARGET_ADDR: cfg_reg.target_addr <= cfg_wdata;
                sspst_pkg::REG_FIRST_PORT:  cfg_reg.first_port  <= cfg_wdata[15:0];
                sspst_pkg::REG_LAST_PORT:   cfg_reg.last_port   <= cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // table clear sweep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else if (clr_active_reg) begin
            clr_addr_reg <= clr_addr_reg + PORT_BITS'(1);
            if (&clr_addr_reg) begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    assign p1_adv  = p1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !clr_active_reg && (!p1_valid_reg || p1_adv);
    assign accept  = s_valid && s_ready;

    assign ram_we    = clr_active_reg || p1_adv;
    assign ram_waddr = clr_active_reg ? clr_addr_reg : p1_item_reg.port[PORT_BITS-1:0];
    assign ram_wdata = clr_active_reg ? sspst_pkg::ST_UNKNOWN : upd.port_status;

    sspst_ram #(
        .WIDTH (2),
        .DEPTH (DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (s_data.port[PORT_BITS-1:0]),
        .rdata (rd_state)
    );

    assign cur_state = fwd_hit_reg ? fwd_data_reg : rd_state;

    sspst_update u_update (
        .item      (p1_item_reg),
        .cur_state (cur_state),
        .cfg       (cfg_reg),
        .result    (upd)
    );

    assign fwd_hit_next = p1_adv &&
        (p1_item_reg.port[PORT_BITS-1:0] == s_data.port[PORT_BITS-1:0]);

    // update stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (accept) begin
            p1_valid_reg <= 1'b1;
        end else if (p1_adv) begin
            p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_item_reg  <= s_data;
            fwd_hit_reg  <= fwd_hit_next;
            fwd_data_reg <= upd.port_status;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (p1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_adv) begin
            m_data_reg <= upd;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== hw/rtl/sspst_checker.sv =====
// Port-level checker for the SYN scan port state table, bound to the top.
module sspst_checker (
    input logic            aclk,
    input logic            aresetn,
    input logic            s_valid,
    input logic            s_ready,
    input logic            m_valid,
    input logic            m_ready,
    input sspst_pkg::out_t m_data
);

    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("s_ready high right after reset");

    a_result_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> ##2 m_valid)
        else $error("no result two cycles after transaction");

    a_no_spurious_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result without input transaction");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result changed");

endmodule

bind syn_scan_port_state_table_top sspst_checker u_sspst_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== tb/tb_syn_scan_port_state_table_top.sv =====
// Self-checking testbench for the SYN scan port state table top level.
`timescale 1ns / 1ps

module tb_syn_scan_port_state_table_top;

    localparam int PORT_BITS = sspst_pkg::PORT_BITS_DEF;
    localparam int IN_W = $bits(sspst_pkg::in_t);
    localparam logic [1:0] ACT_UNDEF = 2'd3;
    localparam logic [7:0] SYN_ACK = sspst_pkg::FLAG_SYN | sspst_pkg::FLAG_ACK;
    localparam int RAND_PHASES = 5;
    localparam int ITEMS_PER_PHASE = 300;
    localparam int POOL_SIZE = 24;

    typedef struct {
        sspst_pkg::in_t  item;
        bit              typed;
        sspst_pkg::out_t want;
    } dir_row_t;

    logic            aclk = 1'b0;
    logic            aresetn = 1'b0;
    logic            s_valid = 1'b0;
    logic            s_ready;
    sspst_pkg::in_t  s_data = '0;
    logic            m_valid;
    logic            m_ready = 1'b0;
    sspst_pkg::out_t m_data;
    logic            cfg_we = 1'b0;
    logic [1:0]      cfg_addr = sspst_pkg::REG_TARGET_ADDR;
    logic [31:0]     cfg_wdata = '0;

    // scoreboard state
    logic [1:0]      port_state_mirror [0:(1 << PORT_BITS) - 1];
    logic [31:0]     tgt_mirror;
    logic [15:0]     lo_mirror;
    logic [15:0]     hi_mirror;
    sspst_pkg::out_t pending_status_q [$];
    logic [15:0]     probe_ports [POOL_SIZE];
    dir_row_t        dir_rows [$];
    int              mismatch_count = 0;
    int              burst_left = 0;
    logic            hold_go = 1'b0;
    bit              hold_done = 1'b0;
    int              hold_left = 0;
    logic [31:0]     rx_cycle = '0;

    syn_scan_port_state_table_top #(
        .PORT_BITS(PORT_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    always #1 aclk = ~aclk;

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic sspst_pkg::out_t scan_table_update(input sspst_pkg::in_t it);
        logic [PORT_BITS-1:0] idx;
        logic [1:0]           st;
        sspst_pkg::out_t      r;
        bit                   ok;
        idx = it.port[PORT_BITS-1:0];
        st = port_state_mirror[idx];
        r = '0;
        case (it.action)
            sspst_pkg::ACT_MARK: begin
                if (st == sspst_pkg::ST_UNKNOWN) st = sspst_pkg::ST_SENT;
            end
            sspst_pkg::ACT_REPLY: begin
                ok = (it.source_addr == tgt_mirror) &&
                     (it.protocol == sspst_pkg::PROTO_TCP) &&
                     (int'(it.packet_length) >= int'(it.header_words) * 4 + 20) &&
                     (it.port >= lo_mirror) && (it.port <= hi_mirror);
                if (!ok) begin
                    r.ignored = 1'b1;
                end else if (st == sspst_pkg::ST_SENT) begin
                    if ((it.tcp_flags & SYN_ACK) == SYN_ACK) begin
                        st = sspst_pkg::ST_OPEN;
                        r.grab_banner = 1'b1;
                    end else if ((it.tcp_flags & sspst_pkg::FLAG_RST) != 8'h00) begin
                        st = sspst_pkg::ST_CLOSED;
                    end
                end
            end
            default: ;
        endcase
        port_state_mirror[idx] = st;
        r.port_status = st;
        return r;
    endfunction

    function automatic sspst_pkg::in_t mk(input logic [1:0] a, input logic [15:0] p,
                                          input logic [31:0] src, input logic [7:0] pr,
                                          input logic [3:0] hw, input logic [15:0] len,
                                          input logic [7:0] fl);
        sspst_pkg::in_t it;
        it.action = a;
        it.port = p;
        it.source_addr = src;
        it.protocol = pr;
        it.header_words = hw;
        it.packet_length = len;
        it.tcp_flags = fl;
        return it;
    endfunction

    task automatic add_row(input sspst_pkg::in_t it, input bit typed,
                           input sspst_pkg::out_t want);
        dir_row_t row;
        row.item = it;
        row.typed = typed;
        row.want = want;
        dir_rows.push_back(row);
    endtask

    function automatic logic [15:0] pick_port();
        if (lo_mirror <= hi_mirror && $urandom_range(0, 9) != 0)
            return 16'(lo_mirror + $urandom_range(0, hi_mirror - lo_mirror));
        return 16'($urandom);
    endfunction

    function automatic sspst_pkg::in_t gen_item();
        logic [95:0]    raw;
        sspst_pkg::in_t it;
        int             k;
        int             sel;
        int             min_len;
        raw = {$urandom, $urandom, $urandom};
        it = raw[IN_W-1:0];
        if ($urandom_range(0, 9) == 0) return it;
        k = $urandom_range(0, POOL_SIZE - 1);
        if ($urandom_range(0, 19) == 0) probe_ports[k] = pick_port();
        it.port = probe_ports[k];
        sel = $urandom_range(0, 99);
        if (sel < 35) begin
            it.action = sspst_pkg::ACT_MARK;
        end else if (sel < 80) begin
            it.action = sspst_pkg::ACT_REPLY;
            if ($urandom_range(0, 9) != 0) it.source_addr = tgt_mirror;
            if ($urandom_range(0, 9) != 0) it.protocol = sspst_pkg::PROTO_TCP;
            min_len = int'(it.header_words) * 4 + 20;
            case ($urandom_range(0, 5))
                0: it.packet_length = 16'(min_len - 1);
                1: it.packet_length = 16'(min_len);
                2: ;
                default: it.packet_length = 16'(min_len + $urandom_range(0, 1400));
            endcase
            case ($urandom_range(0, 4))
                0: it.tcp_flags = SYN_ACK;
                1: it.tcp_flags = sspst_pkg::FLAG_RST;
                2: it.tcp_flags = it.tcp_flags | SYN_ACK;
                3: it.tcp_flags = sspst_pkg::FLAG_ACK | sspst_pkg::FLAG_RST;
                default: ;
            endcase
        end else if (sel < 97) begin
            it.action = sspst_pkg::ACT_QUERY;
        end else begin
            it.action = ACT_UNDEF;
        end
        return it;
    endfunction

    task automatic push_item(input sspst_pkg::in_t it, input bit typed,
                             input sspst_pkg::out_t want);
        sspst_pkg::out_t guess;
        int              gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 48);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        guess = scan_table_update(it);
        pending_status_q.push_back(typed ? want : guess);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        burst_left = 0;
        while (pending_status_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_regs(input logic [31:0] tgt, input logic [15:0] lo,
                              input logic [15:0] hi);
        cfg_we <= 1'b1;
        cfg_addr <= sspst_pkg::REG_TARGET_ADDR;
        cfg_wdata <= tgt;
        @(posedge aclk);
        cfg_addr <= sspst_pkg::REG_FIRST_PORT;
        cfg_wdata <= {16'($urandom), lo};
        @(posedge aclk);
        cfg_addr <= sspst_pkg::REG_LAST_PORT;
        cfg_wdata <= {16'($urandom), hi};
        @(posedge aclk);
        cfg_we <= 1'b0;
        tgt_mirror = tgt;
        lo_mirror = lo;
        hi_mirror = hi;
    endtask

    always @(posedge aclk) begin : result_check
        sspst_pkg::out_t want;
        rx_cycle = rx_cycle + 1;
        if (aresetn && m_valid && m_ready) begin
            if (pending_status_q.size() == 0) begin
                $error("result with no transaction pending: %p", m_data);
                mismatch_count++;
            end else begin
                want = pending_status_q.pop_front();
                if (m_data.port_status !== want.port_status) begin
                    $error("port_status: expected %0d, got %0d",
                           want.port_status, m_data.port_status);
                    mismatch_count++;
                end
                if (m_data.grab_banner !== want.grab_banner) begin
                    $error("grab_banner: expected %0d, got %0d",
                           want.grab_banner, m_data.grab_banner);
                    mismatch_count++;
                end
                if (m_data.ignored !== want.ignored) begin
                    $error("ignored: expected %0d, got %0d", want.ignored, m_data.ignored);
                    mismatch_count++;
                end
            end
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (hold_go && !hold_done) begin
            hold_done = 1'b1;
            hold_left = 399;
            m_ready <= 1'b0;
        end else begin
            case (rx_cycle[7:6])
                2'd0: m_ready <= 1'b1;
                2'd1: m_ready <= ($urandom_range(0, 3) != 0);
                2'd2: m_ready <= ($urandom_range(0, 1) == 0);
                default: m_ready <= (rx_cycle[2:0] != 3'd5 && rx_cycle[2:0] != 3'd6);
            endcase
        end
    end

    initial begin
        logic [31:0] tgt;
        logic [15:0] lo;
        logic [15:0] hi;
        for (int i = 0; i < (1 << PORT_BITS); i++) begin
            port_state_mirror[i] = sspst_pkg::ST_UNKNOWN;
        end
        tgt_mirror = sspst_pkg::TARGET_ADDR_RST;
        lo_mirror = sspst_pkg::FIRST_PORT_RST;
        hi_mirror = sspst_pkg::LAST_PORT_RST;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed checks against reset register values
        add_row(mk(sspst_pkg::ACT_QUERY, 16'd0, 0, 0, 0, 0, 0), 1,
                '{sspst_pkg::ST_UNKNOWN, 1'b0, 1'b0});
        add_row(mk(sspst_pkg::ACT_MARK, 16'd80, 0, 0, 0, 0, 0), 1,
                '{sspst_pkg::ST_SENT, 1'b0, 1'b0});
        add_row(mk(sspst_pkg::ACT_MARK, 16'd80, 0, 0, 0, 0, 0), 1,
                '{sspst_pkg::ST_SENT, 1'b0, 1'b0});
        add_row(mk(sspst_pkg::ACT_REPLY, 16'd80, 0, sspst_pkg::PROTO_TCP, 4'd5, 16'd40,
                   SYN_ACK), 1, '{sspst_pkg::ST_OPEN, 1'b1, 1'b0});
        add_row(mk(sspst_pkg::ACT_REPLY, 16'd80, 0, sspst_pkg::PROTO_TCP, 4'd5, 16'd40,
                   SYN_ACK), 1, '{sspst_pkg::ST_OPEN, 1'b0, 1'b0});
        add_row(mk(sspst_pkg::ACT_MARK, 16'd80, 0, 0, 0, 0, 0), 1,
                '{sspst_pkg::ST_OPEN, 1'b0, 1'b0});
        add_row(mk(sspst_pkg::ACT_MARK, 16'd443, 0, 0, 0, 0, 0), 0, '0);
        add_row(mk(sspst_pkg::ACT_REPLY, 16'd443, 0, sspst_pkg::PROTO_TCP, 4'd5, 16'd40,
                   sspst_pkg::FLAG_RST), 1, '{sspst_pkg::ST_CLOSED, 1'b0, 1'b0});
        add_row(mk(sspst_pkg::ACT_MARK, 16'd22, 0, 0, 0, 0, 0), 0, '0);
        add_row(mk(sspst_pkg::ACT_REPLY, 16'd22, 0, sspst_pkg::PROTO_TCP, 4'd5, 16'd40,
                   sspst_pkg::FLAG_ACK), 1, '{sspst_pkg::ST_SENT, 1'b0, 1'b0});
        add_row(mk(sspst_pkg::ACT_REPLY, 16'd22, 0, sspst_pkg::PROTO_TCP, 4'd5, 16'd40,
                   sspst_pkg::FLAG_SYN), 0, '0);
        add_row(mk(sspst_pkg::ACT_REPLY, 16'd22, 0, 8'd17, 4'd5, 16'd40, SYN_ACK), 1,
                '{sspst_pkg::ST_SENT, 1'b0, 1'b1});
        add_row(mk(sspst_pkg::ACT_REPLY, 16'd22, 32'hFFFF_FFFF, sspst_pkg::PROTO_TCP,
                   4'd5, 16'd40, SYN_ACK), 1, '{sspst_pkg::ST_SENT, 1'b0, 1'b1});
        add_row(mk(sspst_pkg::ACT_REPLY, 16'd22, 0, sspst_pkg::PROTO_TCP, 4'd15, 16'd79,
                   SYN_ACK), 1, '{sspst_pkg::ST_SENT, 1'b0, 1'b1});
        add_row(mk(sspst_pkg::ACT_REPLY, 16'd22, 0, sspst_pkg::PROTO_TCP, 4'd15, 16'd80,
                   SYN_ACK | sspst_pkg::FLAG_RST), 1, '{sspst_pkg::ST_OPEN, 1'b1, 1'b0});
        add_row(mk(sspst_pkg::ACT_MARK, 16'd0, 0, 0, 0, 0, 0), 0, '0);
        add_row(mk(sspst_pkg::ACT_REPLY, 16'd0, 0, sspst_pkg::PROTO_TCP, 4'd5, 16'd40,
                   sspst_pkg::FLAG_RST), 1, '{sspst_pkg::ST_SENT, 1'b0, 1'b1});
        add_row(mk(sspst_pkg::ACT_MARK, 16'hFFFF, 0, 0, 0, 0, 0), 0, '0);
        add_row(mk(sspst_pkg::ACT_REPLY, 16'hFFFF, 0, sspst_pkg::PROTO_TCP, 4'd0, 16'd20,
                   8'hFF), 1, '{sspst_pkg::ST_OPEN, 1'b1, 1'b0});
        add_row(mk(sspst_pkg::ACT_REPLY, 16'd1, 0, sspst_pkg::PROTO_TCP, 4'd0, 16'hFFFF,
                   sspst_pkg::FLAG_RST), 1, '{sspst_pkg::ST_UNKNOWN, 1'b0, 1'b0});
        add_row(mk(ACT_UNDEF, 16'd80, 0, 0, 0, 0, 0), 1,
                '{sspst_pkg::ST_OPEN, 1'b0, 1'b0});
        add_row(mk(sspst_pkg::ACT_QUERY, 16'd443, 0, 0, 0, 0, 0), 1,
                '{sspst_pkg::ST_CLOSED, 1'b0, 1'b0});
        add_row(mk(sspst_pkg::ACT_MARK, 16'd1000, 32'hFFFF_FFFF, 8'hFF, 4'hF, 16'hFFFF,
                   8'hFF), 1, '{sspst_pkg::ST_SENT, 1'b0, 1'b0});
        add_row(mk(sspst_pkg::ACT_REPLY, 16'd1000, 0, sspst_pkg::PROTO_TCP, 4'd0, 16'd0,
                   sspst_pkg::FLAG_RST), 1, '{sspst_pkg::ST_SENT, 1'b0, 1'b1});
        add_row(mk(sspst_pkg::ACT_QUERY, 16'd22, 0, 0, 0, 0, 0), 0, '0);
        foreach (dir_rows[i]) push_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_drained();
            case (ph)
                0: begin tgt = $urandom; lo = 16'd1; hi = 16'hFFFF; end
                1: begin tgt = 32'hFFFF_FFFF; lo = 16'hFFFF; hi = 16'hFFFF; end
                2: begin tgt = 32'd0; lo = 16'hFFFF; hi = 16'd1; end  // empty range
                3: begin
                    tgt = $urandom;
                    lo = 16'($urandom_range(1, 65000));
                    hi = lo + 16'($urandom_range(0, 500));
                end
                default: begin tgt = $urandom; lo = 16'd1; hi = 16'd64; end
            endcase
            write_regs(tgt, lo, hi);
            foreach (probe_ports[k]) probe_ports[k] = pick_port();
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (ph == 0 && n == 150) hold_go <= 1'b1;
                push_item(gen_item(), 1'b0, '0);
            end
        end

        wait_drained();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/sspst_pkg.sv
hw/rtl/sspst_ram.sv
hw/rtl/sspst_update.sv
hw/rtl/syn_scan_port_state_table_top.sv
hw/rtl/sspst_checker.sv
tb/tb_syn_scan_port_state_table_top.sv
